// ===== src/infix_to_postfix_converter_top_assert.svh =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top_assert.svh
// assertion macros used by the converter datapath
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_TOP_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define ITP_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ITP_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define ITP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg
// types, character codes and helper functions of the infix to postfix converter
// ----------------------------------------------------------------------------
package itp_pkg;

   localparam int STACK_DEPTH_DEF = 32;
   localparam int CHAR_W          = 8;
   localparam int ERR_W           = 3;

   localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
   localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
   localparam logic [CHAR_W-1:0] CH_POW   = 8'h5E;
   localparam logic [CHAR_W-1:0] CH_MUL   = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_DIV   = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_ADD   = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_SUB   = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7A;
   localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

   typedef enum logic [2:0] {
      OP_OPEN = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4,
      OP_POW  = 3'd5
   } op_code_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE      = 3'd0,
      ERR_OVERFLOW  = 3'd1,
      ERR_UNMATCHED = 3'd2,
      ERR_UNCLOSED  = 3'd3,
      ERR_INVALID   = 3'd4
   } err_type;

   typedef enum logic [2:0] {
      CLS_LETTER  = 3'd0,
      CLS_OPEN    = 3'd1,
      CLS_CLOSE   = 3'd2,
      CLS_OP      = 3'd3,
      CLS_INVALID = 3'd4
   } char_class_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic    load;
      logic    push;
      logic    pop;
      logic    emit_char;
      logic    emit_top;
      logic    emit_status;
      logic    last;
      logic    flag;
      err_type err_code;
      logic    set_closed;
      logic    finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      char_class_type cls;
      logic           is_end;
      logic           closed;
      logic           cnt_zero;
      logic           cnt_gt1;
      logic           cnt_full;
      logic           top_open;
      logic           below_open;
      logic           top_ge;
      logic           below_ge;
      logic           out_free;
   } status_type;

   function automatic char_class_type classify(input logic [CHAR_W-1:0] c);
      char_class_type cls;
      priority if ((c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z)) begin
         cls = CLS_LETTER;
      end else if (c == CH_OPEN) begin
         cls = CLS_OPEN;
      end else if (c == CH_CLOSE) begin
         cls = CLS_CLOSE;
      end else if (c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV
                   || c == CH_POW) begin
         cls = CLS_OP;
      end else begin
         cls = CLS_INVALID;
      end
      return cls;
   endfunction

   function automatic op_code_type char_to_op(input logic [CHAR_W-1:0] c);
      op_code_type code;
      priority if (c == CH_ADD) begin
         code = OP_ADD;
      end else if (c == CH_SUB) begin
         code = OP_SUB;
      end else if (c == CH_MUL) begin
         code = OP_MUL;
      end else if (c == CH_DIV) begin
         code = OP_DIV;
      end else if (c == CH_POW) begin
         code = OP_POW;
      end else begin
         code = OP_OPEN;
      end
      return code;
   endfunction

   function automatic logic [CHAR_W-1:0] op_char(input op_code_type code);
      logic [CHAR_W-1:0] c;
      unique case (code)
         OP_OPEN: c = CH_OPEN;
         OP_ADD:  c = CH_ADD;
         OP_SUB:  c = CH_SUB;
         OP_MUL:  c = CH_MUL;
         OP_DIV:  c = CH_DIV;
         OP_POW:  c = CH_POW;
         default: c = CH_NONE;
      endcase
      return c;
   endfunction

   function automatic logic [1:0] op_prec(input op_code_type code);
      logic [1:0] p;
      unique case (code)
         OP_ADD, OP_SUB: p = 2'd1;
         OP_MUL, OP_DIV: p = 2'd2;
         OP_POW:         p = 2'd3;
         default:        p = 2'd0;
      endcase
      return p;
   endfunction

endpackage

// ===== src/itp_if.sv =====
// ----------------------------------------------------------------------------
// itp_if
// valid/ready channels carrying infix characters in and postfix results out
// ----------------------------------------------------------------------------
interface itp_req_if;
   logic                      valid;
   logic                      ready;
   logic [itp_pkg::CHAR_W-1:0] in_char;
   logic                      end_of_expr;

   modport source (output valid, output in_char, output end_of_expr, input ready);
   modport sink   (input valid, input in_char, input end_of_expr, output ready);
endinterface

interface itp_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [itp_pkg::CHAR_W-1:0] out_char;
   logic                      has_char;
   logic                      last;
   logic                      expr_done;
   logic [itp_pkg::ERR_W-1:0]  error_code;

   modport source (output valid, output out_char, output has_char, output last,
                   output expr_done, output error_code, input ready);
   modport sink   (input valid, input out_char, input has_char, input last,
                   input expr_done, input error_code, output ready);
endinterface

// ===== src/itp_ctrl.sv =====
// ----------------------------------------------------------------------------
// itp_ctrl
// sequencer: takes one item, then, while results can be written, steps it one stack action per cycle
// ----------------------------------------------------------------------------
module itp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  itp_pkg::status_type st,
   output itp_pkg::cmd_type    cmd
);
   import itp_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      pop_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (cmd.finish) state_in = ST_IDLE;
         end
      endcase
   end

   // operator on top of the stack
   assign pop_ok = !st.cnt_zero && !st.top_open;

   // outputs
   always_comb begin
      cmd          = '0;
      cmd.err_code = ERR_NONE;
      req_ready    = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
         end
         ST_EXEC: begin
            priority if (st.is_end) begin
               priority if (pop_ok) begin
                  if (st.out_free) begin
                     cmd.pop      = 1'b1;
                     cmd.emit_top = 1'b1;
                  end
               end else if (!st.cnt_zero) begin
                  // leftover open paren is dropped
                  cmd.pop      = 1'b1;
                  cmd.flag     = 1'b1;
                  cmd.err_code = ERR_UNCLOSED;
               end else begin
                  if (st.out_free) begin
                     cmd.emit_status = 1'b1;
                     cmd.last        = 1'b1;
                     cmd.finish      = 1'b1;
                  end
               end
            end else if (st.closed) begin
               cmd.finish = 1'b1;
            end else begin
               unique case (st.cls)
                  CLS_LETTER: begin
                     if (st.out_free) begin
                        cmd.emit_char = 1'b1;
                        cmd.last      = 1'b1;
                        cmd.finish    = 1'b1;
                     end
                  end
                  CLS_OPEN: begin
                     if (st.cnt_full) begin
                        cmd.flag     = 1'b1;
                        cmd.err_code = ERR_OVERFLOW;
                     end else begin
                        cmd.push = 1'b1;
                     end
                     cmd.finish = 1'b1;
                  end
                  CLS_CLOSE: begin
                     priority if (pop_ok) begin
                        if (st.out_free) begin
                           cmd.pop      = 1'b1;
                           cmd.emit_top = 1'b1;
                           cmd.last     = !(st.cnt_gt1 && !st.below_open);
                        end
                     end else if (!st.cnt_zero) begin
                        cmd.pop    = 1'b1;
                        cmd.finish = 1'b1;
                     end else begin
                        cmd.flag       = 1'b1;
                        cmd.err_code   = ERR_UNMATCHED;
                        cmd.set_closed = 1'b1;
                        cmd.finish     = 1'b1;
                     end
                  end
                  CLS_OP: begin
                     priority if (pop_ok && st.top_ge) begin
                        if (st.out_free) begin
                           cmd.pop      = 1'b1;
                           cmd.emit_top = 1'b1;
                           cmd.last     = !(st.cnt_gt1 && !st.below_open && st.below_ge);
                        end
                     end else begin
                        if (st.cnt_full) begin
                           cmd.flag     = 1'b1;
                           cmd.err_code = ERR_OVERFLOW;
                        end else begin
                           cmd.push = 1'b1;
                        end
                        cmd.finish = 1'b1;
                     end
                  end
                  CLS_INVALID: begin
                     cmd.flag     = 1'b1;
                     cmd.err_code = ERR_INVALID;
                     cmd.finish   = 1'b1;
                  end
                  default: begin
                     cmd.finish = 1'b1;
                  end
               endcase
            end
         end
      endcase
   end

endmodule

// ===== src/itp_dp.sv =====
// ----------------------------------------------------------------------------
// itp_dp
// datapath: input holding register, operator stack, error state, result register
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_top_assert.svh"

module itp_dp #(
   parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [itp_pkg::CHAR_W-1:0] req_in_char,
   input  logic                       req_end_of_expr,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [itp_pkg::CHAR_W-1:0] rsp_out_char,
   output logic                       rsp_has_char,
   output logic                       rsp_last,
   output logic                       rsp_expr_done,
   output logic [itp_pkg::ERR_W-1:0]  rsp_error_code,
   input  itp_pkg::cmd_type           cmd,
   output itp_pkg::status_type        st
);
   import itp_pkg::*;

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   logic [CHAR_W-1:0] char_ff;
   logic              end_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic [CNT_W-1:0]  rd_idx;
   logic [ADDR_W-1:0] rd_addr;
   op_code_type       stack_mem [STACK_DEPTH];
   op_code_type       top_ff;
   op_code_type       top_in;
   op_code_type       below_ff;
   op_code_type       in_code;
   err_type           err_ff;
   err_type           err_in;
   logic              closed_ff;
   logic              closed_in;
   logic              emitting;
   logic              out_free;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff;
   logic              rsp_has_ff;
   logic              rsp_last_ff;
   logic              rsp_done_ff;
   err_type           rsp_err_ff;

   assign in_code  = char_to_op(char_ff);
   assign emitting = cmd.emit_char || cmd.emit_top || cmd.emit_status;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // input holding register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         char_ff <= req_in_char;
         end_ff  <= req_end_of_expr;
      end
   end

   // stack: top kept in a register, the entry below it read ahead from memory
   always_comb begin
      cnt_in = cnt_ff;
      top_in = top_ff;
      priority if (cmd.emit_status) begin
         cnt_in = '0;
      end else if (cmd.push) begin
         cnt_in = cnt_ff + CNT_W'(1);
         top_in = in_code;
      end else if (cmd.pop) begin
         cnt_in = cnt_ff - CNT_W'(1);
         top_in = below_ff;
      end
   end

   assign rd_idx  = cnt_in - CNT_W'(2);
   assign rd_addr = rd_idx[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_mem[cnt_ff[ADDR_W-1:0]] <= in_code;
      end
      below_ff <= stack_mem[rd_addr];
      top_ff   <= top_in;
   end

   always_comb begin
      err_in    = err_ff;
      closed_in = closed_ff;
      if (cmd.emit_status) begin
         err_in    = ERR_NONE;
         closed_in = 1'b0;
      end else begin
         // first error of the expression sticks
         if (cmd.flag && err_ff == ERR_NONE) err_in = cmd.err_code;
         if (cmd.set_closed) closed_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         err_ff    <= ERR_NONE;
         closed_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         err_ff    <= err_in;
         closed_ff <= closed_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emitting) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emitting) begin
         rsp_last_ff <= cmd.last;
         rsp_done_ff <= cmd.emit_status;
         rsp_has_ff  <= !cmd.emit_status;
         priority if (cmd.emit_char) begin
            rsp_char_ff <= char_ff;
            rsp_err_ff  <= ERR_NONE;
         end else if (cmd.emit_top) begin
            rsp_char_ff <= op_char(top_ff);
            rsp_err_ff  <= ERR_NONE;
         end else begin
            rsp_char_ff <= CH_NONE;
            rsp_err_ff  <= err_ff;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_char   = rsp_char_ff;
   assign rsp_has_char   = rsp_has_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_expr_done  = rsp_done_ff;
   assign rsp_error_code = rsp_err_ff;

   // status to the controller
   always_comb begin
      st.cls        = classify(char_ff);
      st.is_end     = end_ff;
      st.closed     = closed_ff;
      st.cnt_zero   = (cnt_ff == '0);
      st.cnt_gt1    = (cnt_ff > CNT_W'(1));
      st.cnt_full   = (cnt_ff == CNT_W'(STACK_DEPTH));
      st.top_open   = (top_ff == OP_OPEN);
      st.below_open = (below_ff == OP_OPEN);
      st.top_ge     = (op_prec(top_ff) >= op_prec(in_code));
      st.below_ge   = (op_prec(below_ff) >= op_prec(in_code));
      st.out_free   = out_free;
   end

   `ITP_ASSERT_ALWAYS(a_cnt_bound, cnt_ff <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
   `ITP_ASSERT_IMPLIES(a_push_room, cmd.push, cnt_ff != CNT_W'(STACK_DEPTH), "push on full stack")
   `ITP_ASSERT_IMPLIES(a_pop_nonempty, cmd.pop, cnt_ff != '0, "pop on empty stack")
   `ITP_ASSERT_IMPLIES(a_emit_room, emitting, out_free, "result overwritten while stalled")
   `ITP_ASSERT_NEXT(a_status_clear, cmd.emit_status, cnt_ff == '0 && err_ff == ERR_NONE && !closed_ff, "expression state not cleared")

endmodule

// ===== src/infix_to_postfix_converter_top.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top
// shunting-yard conversion of an infix character stream to postfix
// ----------------------------------------------------------------------------
// req_chan carries one infix character per item, or an end marker
// (end_of_expr = 1) that closes the expression. rsp_chan returns the postfix
// characters; the result that ends an expression is status only, with
// expr_done set and the first error of the expression in error_code. last
// marks the final result caused by one input item.
// Sequencing: an item is taken when the block is idle, then handled one
// stack action per cycle, pausing while a result cannot be written: an
// action for each operator popped and each leftover '(' dropped at the end
// marker, and a final action that decides the item. A letter passes the
// input holding register and the result register before it is presented on
// rsp_chan; a new item is taken on the cycle after the last action, so the
// block takes no new item before it is done with the last. Each operator
// pushed is popped once. The operator stack memory has one write and one read-ahead of the entry below the top.
// A stalled rsp_chan holds its result register; stepping pauses only when
// another result must be written, and the next item can still be taken.
// Reset empties the stack and clears the error and early-close state; no
// clearing pass is needed, stack entries are only used after being written.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top #(
   parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   itp_req_if.sink   req_chan,
   itp_rsp_if.source rsp_chan
);
   import itp_pkg::*;

   cmd_type    cmd;
   status_type st;

   itp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .st        (st),
      .cmd       (cmd)
   );

   itp_dp #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_in_char     (req_chan.in_char),
      .req_end_of_expr (req_chan.end_of_expr),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_out_char    (rsp_chan.out_char),
      .rsp_has_char    (rsp_chan.has_char),
      .rsp_last        (rsp_chan.last),
      .rsp_expr_done   (rsp_chan.expr_done),
      .rsp_error_code  (rsp_chan.error_code),
      .cmd             (cmd),
      .st              (st)
   );

endmodule
